FILE: sv/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg: shared types and constants of the insertion sorter
// Store depth, counter width, the value type, the per-cell control bundle and
// the controller states.
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int DEPTH = 64;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;

    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic [CNT_W-1:0]        count_t;

    typedef struct packed {
        logic insert;     // a request is being inserted this cycle
        logic shift;      // drain: take the right neighbour's entry
        logic occupied;   // this cell holds a value of the batch
        logic free_slot;  // this cell is the first empty place
    } cell_ctrl_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

endpackage

FILE: sv/isort_cell.sv
// ----------------------------------------------------------------------------
// isort_cell: one place of the sorted row
// Holds one value; on insertion it either keeps its value, takes the left
// neighbour's value or takes the new value; on drain it takes the right
// neighbour's value.
// ----------------------------------------------------------------------------
module isort_cell (
    input  logic                   clk,
    input  isort_pkg::cell_ctrl_t  ctrl,
    input  isort_pkg::value_t      value_in,
    input  logic                   left_gt,
    input  isort_pkg::value_t      left_value,
    input  isort_pkg::value_t      right_value,
    output logic                   gt,
    output isort_pkg::value_t      value
);
    import isort_pkg::*;

    value_t value_reg;
    value_t value_next;

    // strictly greater: an equal value lands above the held ones
    assign gt    = ctrl.occupied && (value_reg > value_in);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift)
        begin
            value_next = right_value;
        end
        else if (ctrl.insert && (gt || ctrl.free_slot))
        begin
            value_next = left_gt ? left_value : value_in;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

FILE: sv/insertion_sorter.sv
// ----------------------------------------------------------------------------
// insertion_sorter: batch sorter built from a row of compare-and-shift cells
// Values enter one per request; the item marked last starts an ascending
// read-out of the whole batch.
// ----------------------------------------------------------------------------
// A request is taken on any cycle where start is high and busy is low, so a
// batch loads at one value per cycle: every cell compares the new value with
// its own entry in parallel and the larger entries move up one place in that
// same cycle. Up to DEPTH values are kept; further values of the batch are
// dropped and every result of that batch then has overflow set. The request
// marked last is inserted (unless the row is full) and busy rises on the next
// cycle and stays high while the n values held are read out: the row
// shifts down through cell 0 and one result per cycle appears with
// result_strobe high, the final one with last_value high. The receiver must
// take each result in the cycle it is shown; nothing is held back.
// ----------------------------------------------------------------------------
module insertion_sorter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  isort_pkg::value_t  value,
    input  logic               last_item,
    output logic               result_strobe,
    output isort_pkg::value_t  sorted_value,
    output logic               last_value,
    output logic               overflow
);
    import isort_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    count_t     count_reg;
    count_t     count_next;
    logic       overflow_reg;
    logic       overflow_next;

    logic       accept;
    logic       full;
    logic       do_insert;
    logic       do_shift;

    cell_ctrl_t ctrl [DEPTH];
    logic       gt   [DEPTH];
    value_t     cell_value [DEPTH];

    assign busy      = (state_reg == ST_DRAIN);
    assign accept    = start && !busy;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign do_insert = accept && !full;
    assign do_shift  = (state_reg == ST_DRAIN);

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic   l_gt;
            value_t l_value;
            value_t r_value;

            assign ctrl[i].insert    = do_insert;
            assign ctrl[i].shift     = do_shift;
            assign ctrl[i].occupied  = (CNT_W'(i) < count_reg);
            assign ctrl[i].free_slot = (CNT_W'(i) == count_reg);

            if (i == 0)
            begin : g_first
                assign l_gt    = 1'b0;
                assign l_value = value;
            end
            else
            begin : g_inner
                assign l_gt    = gt[i-1];
                assign l_value = cell_value[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_end
                assign r_value = cell_value[i];
            end
            else
            begin : g_mid
                assign r_value = cell_value[i+1];
            end

            isort_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl[i]),
                .value_in    (value),
                .left_gt     (l_gt),
                .left_value  (l_value),
                .right_value (r_value),
                .gt          (gt[i]),
                .value       (cell_value[i])
            );
        end
    endgenerate

    assign result_strobe = do_shift;
    assign sorted_value  = cell_value[0];
    assign last_value    = do_shift && (count_reg == CNT_W'(1));
    assign overflow      = overflow_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last_item)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                count_next = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    // batch done: empty the row for the next one
                    overflow_next = 1'b0;
                    state_next    = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (count_reg != '0))
        else $error("result shown from an empty row");

    a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_item) |=> result_strobe)
        else $error("last request did not start the read-out");

    a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last_value) |=> (!result_strobe && !busy && !overflow))
        else $error("read-out did not end after the final result");

    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last_value) |=>
            ($signed($past(sorted_value)) <= $signed(sorted_value)))
        else $error("results out of order");

endmodule
